// ===== src/assert_macros.svh =====
// Assertion macros shared by the divider RTL.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IDIV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define IDIV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/idiv_pkg.sv =====
// Types and constants for the integer divider.
// No dependencies; used by the top level.
package idiv_pkg;

    localparam int unsigned FIELD_W = 64;

    typedef struct packed {
        logic               mode;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               div_by_zero;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS_A,
        ST_ABS_B,
        ST_DIV,
        ST_SGN_Q,
        ST_SGN_R
    } t_state;

endpackage

// ===== src/idiv_alu.sv =====
// Shared subtractor of the divider: difference and no-borrow flag.
// Depends on nothing; instantiated by int64_divider_signed_unsigned.
module idiv_alu #(
    parameter int unsigned WIDTH = 64
) (
    input  logic [WIDTH:0] i_op_a,
    input  logic [WIDTH:0] i_op_b,
    output logic [WIDTH:0] o_diff,
    output logic           o_ge
);

    logic [WIDTH+1:0] w_full;

    assign w_full = {1'b0, i_op_a} - {1'b0, i_op_b};
    assign o_diff = w_full[WIDTH:0];
    assign o_ge   = ~w_full[WIDTH+1];

endmodule

// ===== src/int64_divider_signed_unsigned.sv =====
// Integer divider, unsigned or signed, quotient and remainder.
// Depends on idiv_pkg, idiv_alu and assert_macros.svh.
//
//  channel   | ports                  | handshake
//  ----------+------------------------+------------------------------
//  request   | i_req (t_div_req)      | taken when start && !busy
//  result    | o_rsp (t_div_rsp)      | o_done high for one cycle
//
// A transaction passes ST_ABS_A and ST_ABS_B for the operand magnitudes,
// DATA_WIDTH restoring steps in ST_DIV, ST_SGN_Q and ST_SGN_R for the
// result signs, and then raises the result strobe back in ST_IDLE.
// All of it runs through the one subtractor in idiv_alu.
// busy stays high from accept until the result cycle; the result is
// presented once and cannot be stalled. Reset is synchronous, active low.
`include "assert_macros.svh"

module int64_divider_signed_unsigned #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  idiv_pkg::t_div_req i_req,
    output idiv_pkg::t_div_rsp o_rsp,
    output logic              o_done
);

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned CW = $clog2(DATA_WIDTH);

    idiv_pkg::t_state r_state, n_state;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic [W-1:0]     r_a, n_a;      // dividend, then quotient
    logic [W-1:0]     r_b, n_b;      // divisor
    logic [W-1:0]     r_rem, n_rem;
    logic             r_neg_a, n_neg_a;
    logic             r_neg_b, n_neg_b;
    logic             r_dbz, n_dbz;
    idiv_pkg::t_div_rsp r_rsp, n_rsp;

    logic [W:0]       w_op_a, w_op_b, w_diff;
    logic             w_ge;
    logic [W:0]       w_rem_sh;
    logic [W-1:0]     w_in_a, w_in_b;

    assign w_in_a   = i_req.dividend[W-1:0];
    assign w_in_b   = i_req.divisor[W-1:0];
    assign w_rem_sh = {r_rem, r_a[W-1]};

    // Operand select for the shared subtractor
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            idiv_pkg::ST_ABS_A: begin
                w_op_b = {1'b0, r_a};
            end
            idiv_pkg::ST_ABS_B: begin
                w_op_b = {1'b0, r_b};
            end
            idiv_pkg::ST_DIV: begin
                w_op_a = w_rem_sh;
                w_op_b = {1'b0, r_b};
            end
            idiv_pkg::ST_SGN_Q: begin
                w_op_b = {1'b0, r_a};
            end
            idiv_pkg::ST_SGN_R: begin
                w_op_b = {1'b0, r_rem};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    idiv_alu #(
        .WIDTH(W)
    ) u_alu (
        .i_op_a(w_op_a),
        .i_op_b(w_op_b),
        .o_diff(w_diff),
        .o_ge  (w_ge)
    );

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_b     = r_b;
        n_rem   = r_rem;
        n_neg_a = r_neg_a;
        n_neg_b = r_neg_b;
        n_dbz   = r_dbz;
        n_rsp   = r_rsp;
        case (r_state)
            idiv_pkg::ST_IDLE: begin
                if (start) begin
                    n_a     = w_in_a;
                    n_b     = w_in_b;
                    n_rem   = '0;
                    n_neg_a = i_req.mode & w_in_a[W-1];
                    n_neg_b = i_req.mode & w_in_b[W-1];
                    n_dbz   = (w_in_b == '0);
                    n_state = idiv_pkg::ST_ABS_A;
                end
            end
            idiv_pkg::ST_ABS_A: begin
                if (r_neg_a) begin
                    n_a = w_diff[W-1:0];
                end
                n_state = idiv_pkg::ST_ABS_B;
            end
            idiv_pkg::ST_ABS_B: begin
                if (r_neg_b) begin
                    n_b = w_diff[W-1:0];
                end
                n_cnt   = '0;
                n_state = idiv_pkg::ST_DIV;
            end
            idiv_pkg::ST_DIV: begin
                // restoring step: keep the difference when it does not borrow
                if (w_ge) begin
                    n_rem = w_diff[W-1:0];
                end else begin
                    n_rem = w_rem_sh[W-1:0];
                end
                n_a   = {r_a[W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_state = idiv_pkg::ST_SGN_Q;
                end
            end
            idiv_pkg::ST_SGN_Q: begin
                if (r_neg_a ^ r_neg_b) begin
                    n_a = w_diff[W-1:0];
                end
                n_state = idiv_pkg::ST_SGN_R;
            end
            idiv_pkg::ST_SGN_R: begin
                n_rsp.div_by_zero = r_dbz;
                if (r_dbz) begin
                    n_rsp.quotient  = '0;
                    n_rsp.remainder = '0;
                end else begin
                    n_rsp.quotient  = idiv_pkg::FIELD_W'(r_a);
                    n_rsp.remainder = r_neg_a ? idiv_pkg::FIELD_W'(w_diff[W-1:0])
                                              : idiv_pkg::FIELD_W'(r_rem);
                end
                n_done  = 1'b1;
                n_state = idiv_pkg::ST_IDLE;
            end
            default: begin
                n_state = idiv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idiv_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_a     <= n_a;
        r_b     <= n_b;
        r_rem   <= n_rem;
        r_neg_a <= n_neg_a;
        r_neg_b <= n_neg_b;
        r_dbz   <= n_dbz;
        r_rsp   <= n_rsp;
    end

    assign busy   = (r_state != idiv_pkg::ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `IDIV_ASSERT_NXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")
    `IDIV_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `IDIV_ASSERT_NOW(a_done_idle, o_done, !busy, "result strobe while still busy")
    `IDIV_ASSERT_NOW(a_dbz_zero, o_done && o_rsp.div_by_zero,
        o_rsp.quotient == '0 && o_rsp.remainder == '0, "non-zero result on divide by zero")

endmodule
